/* rtl/sync_length_checksum_frame_parser_macros.svh */
// Assertion macros used by the checker module of the frame parser.
`ifndef SYNC_LENGTH_CHECKSUM_FRAME_PARSER_MACROS_SVH
`define SYNC_LENGTH_CHECKSUM_FRAME_PARSER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SLCFP_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SLCFP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* rtl/slcfp_pkg.sv */
// Types and constants shared by the frame parser modules.
package slcfp_pkg;

  // Sync pair and framing overhead (two sync bytes, length, checksum).
  localparam logic [7:0] SYNC_FIRST     = 8'h55;
  localparam logic [7:0] SYNC_SECOND    = 8'hAA;
  localparam int unsigned FRAME_OVERHEAD = 4;

  // Frame status codes carried on the result channel.
  localparam logic [1:0] ST_GOOD     = 2'd0;
  localparam logic [1:0] ST_CHECKSUM = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  // Largest payload length that the 6-bit length field can show.
  localparam logic [7:0] PLEN_SAT = 8'd63;

  // End-of-frame event from the receiver to the read-out sequencer.
  typedef struct packed {
    logic       valid;
    logic [1:0] status;
    logic [5:0] plen;
    logic [7:0] count;
  } end_evt_t;

endpackage

/* rtl/sync_length_checksum_frame_parser.sv */
// Sync/length/checksum frame parser. While receiving, the parser takes one byte
// per clock cycle: it hunts for the sync pair 0x55 0xAA, captures the length L,
// writes the payload into the payload store and keeps a mod-256 running sum.
// A frame that passes its checksum is read back from the store at one result per
// cycle while the output is not stalled; the input is held off during read-out
// and until the last result has left the read stage. A checksum mismatch, an
// overflow beyond MAX_FRAME_LEN bytes, or an empty frame yields one status-only
// result with no read-out and holds the input off while that result sits in the
// read stage. A result waiting in the output register stops reception only while a
// second result waits behind it in the read stage. The store needs no clearing
// after reset.
module sync_length_checksum_frame_parser #(
  parameter int MAX_FRAME_LEN = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_rx_byte,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_payload_byte,
  output logic [5:0] out_byte_index,
  output logic       out_has_payload,
  output logic [1:0] out_frame_status,
  output logic [5:0] out_payload_length,
  output logic       out_last
);

  localparam int POS_W  = $clog2(MAX_FRAME_LEN + 1);
  localparam int DEPTH  = MAX_FRAME_LEN - 3;
  localparam int ADDR_W = $clog2(DEPTH);

  logic                take;
  logic                accept_ok;
  logic                wr_en;
  logic [ADDR_W-1:0]   wr_addr;
  logic [7:0]          wr_data;
  logic                rd_en;
  logic [ADDR_W-1:0]   rd_addr;
  logic [7:0]          rd_data;
  slcfp_pkg::end_evt_t frame_end;

  // Reception pauses while a verified payload is read back or a result waits in the read stage.
  assign in_ready = accept_ok;
  assign take     = in_valid && in_ready;

  slcfp_rx #(
    .MAX_FRAME_LEN (MAX_FRAME_LEN),
    .POS_W         (POS_W),
    .ADDR_W        (ADDR_W)
  ) u_rx (
    .clk       (clk),
    .rst_n     (rst_n),
    .take      (take),
    .rx_byte   (in_rx_byte),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .frame_end (frame_end)
  );

  slcfp_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  slcfp_emit #(
    .ADDR_W (ADDR_W)
  ) u_emit (
    .clk                (clk),
    .rst_n              (rst_n),
    .frame_end          (frame_end),
    .accept_ok          (accept_ok),
    .rd_en              (rd_en),
    .rd_addr            (rd_addr),
    .rd_data            (rd_data),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_payload_byte   (out_payload_byte),
    .out_byte_index     (out_byte_index),
    .out_has_payload    (out_has_payload),
    .out_frame_status   (out_frame_status),
    .out_payload_length (out_payload_length),
    .out_last           (out_last)
  );

endmodule

/* rtl/slcfp_ram.sv */
// Payload store with one write port and a registered read port.
module slcfp_ram #(
  parameter int DEPTH  = 61,
  parameter int ADDR_W = 6
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [7:0]        wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [7:0]        rd_data
);

  logic [7:0] mem [DEPTH];
  logic [7:0] rd_data_r;

  // Write port; entries have no reset and are always written before read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read data holds its value until the next read is enabled.
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

/* rtl/slcfp_rx.sv */
// Receive side: sync hunt, length capture, running checksum and payload writes.
module slcfp_rx #(
  parameter int MAX_FRAME_LEN = 64,
  parameter int POS_W         = 7,
  parameter int ADDR_W        = 6
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 take,
  input  logic [7:0]           rx_byte,
  output logic                 wr_en,
  output logic [ADDR_W-1:0]    wr_addr,
  output logic [7:0]           wr_data,
  output slcfp_pkg::end_evt_t  frame_end
);

  localparam int CMP_W = (POS_W > 9) ? POS_W + 1 : 10;
  localparam logic [POS_W-1:0] POS_HUNT   = POS_W'(0);
  localparam logic [POS_W-1:0] POS_SYNC2  = POS_W'(1);
  localparam logic [POS_W-1:0] POS_LENGTH = POS_W'(2);
  localparam logic [POS_W-1:0] POS_LIMIT  = POS_W'(MAX_FRAME_LEN);
  localparam logic [POS_W-1:0] HDR_BYTES  = POS_W'(3);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       len_r, len_nxt;
  logic [7:0]       sum_r, sum_nxt;
  logic [POS_W-1:0] slot;
  logic             is_cksum;

  // Payload slot of the current byte and detection of the checksum byte.
  assign slot     = pos_r - HDR_BYTES;
  assign is_cksum = (CMP_W'(pos_r) + CMP_W'(1)) ==
                    (CMP_W'(len_r) + CMP_W'(slcfp_pkg::FRAME_OVERHEAD));

  // Next-state logic for one accepted byte.
  always_comb begin
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    sum_nxt   = sum_r;
    wr_en     = 1'b0;
    wr_addr   = slot[ADDR_W-1:0];
    wr_data   = rx_byte;
    frame_end = '0;
    if (take) begin
      if (pos_r == POS_HUNT) begin
        if (rx_byte == slcfp_pkg::SYNC_FIRST) begin
          sum_nxt = rx_byte;
          pos_nxt = POS_SYNC2;
        end
      end else if (pos_r == POS_SYNC2) begin
        if (rx_byte == slcfp_pkg::SYNC_SECOND) begin
          sum_nxt = sum_r + rx_byte;
          pos_nxt = POS_LENGTH;
        end else begin
          pos_nxt = POS_HUNT;
        end
      end else if (pos_r == POS_LENGTH) begin
        len_nxt = rx_byte;
        sum_nxt = sum_r + rx_byte;
        pos_nxt = HDR_BYTES;
      end else if (pos_r >= POS_LIMIT) begin
        // Frame has outgrown the maximum size: drop it and report.
        pos_nxt          = POS_HUNT;
        frame_end.valid  = 1'b1;
        frame_end.status = slcfp_pkg::ST_OVERFLOW;
        frame_end.plen   = (len_r > slcfp_pkg::PLEN_SAT) ? 6'd63 : len_r[5:0];
        frame_end.count  = len_r;
      end else if (is_cksum) begin
        pos_nxt          = POS_HUNT;
        frame_end.valid  = 1'b1;
        frame_end.status = (rx_byte == sum_r) ? slcfp_pkg::ST_GOOD
                                              : slcfp_pkg::ST_CHECKSUM;
        frame_end.plen   = len_r[5:0];
        frame_end.count  = len_r;
      end else begin
        wr_en   = 1'b1;
        sum_nxt = sum_r + rx_byte;
        pos_nxt = pos_r + POS_W'(1);
      end
    end
  end

  // Frame position, length and running sum registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= POS_HUNT;
      len_r <= 8'd0;
      sum_r <= 8'd0;
    end else begin
      pos_r <= pos_nxt;
      len_r <= len_nxt;
      sum_r <= sum_nxt;
    end
  end

endmodule

/* rtl/slcfp_emit.sv */
// Read-out sequencer: memory read stage and output register of the result channel.
module slcfp_emit #(
  parameter int ADDR_W = 6
) (
  input  logic                clk,
  input  logic                rst_n,
  input  slcfp_pkg::end_evt_t frame_end,
  output logic                accept_ok,
  output logic                rd_en,
  output logic [ADDR_W-1:0]   rd_addr,
  input  logic [7:0]          rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [7:0]          out_payload_byte,
  output logic [5:0]          out_byte_index,
  output logic                out_has_payload,
  output logic [1:0]          out_frame_status,
  output logic [5:0]          out_payload_length,
  output logic                out_last
);

  // Read-out control.
  logic       busy_r, busy_nxt;
  logic [7:0] rd_idx_r, rd_idx_nxt;
  logic [7:0] cnt_r, cnt_nxt;

  // Read stage (data sits in the memory's read register).
  logic       s1_v_r, s1_v_nxt;
  logic       s1_has_r, s1_has_nxt;
  logic [1:0] s1_status_r, s1_status_nxt;
  logic [5:0] s1_idx_r, s1_idx_nxt;
  logic [5:0] s1_len_r, s1_len_nxt;
  logic       s1_last_r, s1_last_nxt;

  // Output register.
  logic       out_v_r;
  logic [7:0] out_byte_r;
  logic [5:0] out_idx_r;
  logic       out_has_r;
  logic [1:0] out_status_r;
  logic [5:0] out_len_r;
  logic       out_last_r;

  logic out_load;
  logic s1_free;
  logic rd_last;

  assign out_load  = !out_v_r || out_ready;
  assign s1_free   = !s1_v_r || out_load;
  assign rd_en     = busy_r && s1_free;
  assign rd_addr   = rd_idx_r[ADDR_W-1:0];
  assign rd_last   = ({1'b0, rd_idx_r} + 9'd1) == {1'b0, cnt_r};
  assign accept_ok = !busy_r && !s1_v_r;

  // Sequencing of reads and loading of the read stage.
  always_comb begin
    busy_nxt      = busy_r;
    rd_idx_nxt    = rd_idx_r;
    cnt_nxt       = cnt_r;
    s1_v_nxt      = s1_v_r && !out_load;
    s1_has_nxt    = s1_has_r;
    s1_status_nxt = s1_status_r;
    s1_idx_nxt    = s1_idx_r;
    s1_len_nxt    = s1_len_r;
    s1_last_nxt   = s1_last_r;
    if (rd_en) begin
      s1_v_nxt      = 1'b1;
      s1_has_nxt    = 1'b1;
      s1_status_nxt = slcfp_pkg::ST_GOOD;
      s1_idx_nxt    = rd_idx_r[5:0];
      s1_len_nxt    = cnt_r[5:0];
      s1_last_nxt   = rd_last;
      rd_idx_nxt    = rd_idx_r + 8'd1;
      if (rd_last) begin
        busy_nxt = 1'b0;
      end
    end else if (frame_end.valid) begin
      if (frame_end.status == slcfp_pkg::ST_GOOD && frame_end.count != 8'd0) begin
        // Verified frame with payload: start reading the store.
        busy_nxt   = 1'b1;
        rd_idx_nxt = 8'd0;
        cnt_nxt    = frame_end.count;
      end else begin
        // Status-only result.
        s1_v_nxt      = 1'b1;
        s1_has_nxt    = 1'b0;
        s1_status_nxt = frame_end.status;
        s1_idx_nxt    = 6'd0;
        s1_len_nxt    = frame_end.plen;
        s1_last_nxt   = 1'b1;
      end
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r  <= 1'b0;
      s1_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      s1_v_r <= s1_v_nxt;
      if (out_load) begin
        out_v_r <= s1_v_r;
      end
    end
  end

  // Payload registers of the sequencer, read stage and output.
  always_ff @(posedge clk) begin
    rd_idx_r    <= rd_idx_nxt;
    cnt_r       <= cnt_nxt;
    s1_has_r    <= s1_has_nxt;
    s1_status_r <= s1_status_nxt;
    s1_idx_r    <= s1_idx_nxt;
    s1_len_r    <= s1_len_nxt;
    s1_last_r   <= s1_last_nxt;
    if (out_load) begin
      out_byte_r   <= s1_has_r ? rd_data : 8'd0;
      out_idx_r    <= s1_idx_r;
      out_has_r    <= s1_has_r;
      out_status_r <= s1_status_r;
      out_len_r    <= s1_len_r;
      out_last_r   <= s1_last_r;
    end
  end

  assign out_valid          = out_v_r;
  assign out_payload_byte   = out_byte_r;
  assign out_byte_index     = out_idx_r;
  assign out_has_payload    = out_has_r;
  assign out_frame_status   = out_status_r;
  assign out_payload_length = out_len_r;
  assign out_last           = out_last_r;

endmodule

/* rtl/slcfp_checker.sv */
// Port-level checker for the frame parser and its bind statement.
`include "sync_length_checksum_frame_parser_macros.svh"

module slcfp_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic [7:0] in_rx_byte,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_payload_byte,
  input logic [5:0] out_byte_index,
  input logic       out_has_payload,
  input logic [1:0] out_frame_status,
  input logic [5:0] out_payload_length,
  input logic       out_last
);

  // A stalled result keeps its payload byte, index and last flag.
  `SLCFP_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_payload_byte) && $stable(out_byte_index) && $stable(out_last), "result changed while stalled")

  // Status-only results always close their run and carry a zero byte and index.
  `SLCFP_ASSERT_IMP(a_status_last, clk, rst_n, out_valid && !out_has_payload, out_last && out_payload_byte == 8'd0 && out_byte_index == 6'd0, "status-only result malformed")

  // Failed frames never carry payload.
  `SLCFP_ASSERT_IMP(a_fail_no_data, clk, rst_n, out_valid && out_frame_status != slcfp_pkg::ST_GOOD, !out_has_payload, "failed frame carried payload")

  // A payload byte lies inside the declared length.
  `SLCFP_ASSERT_IMP(a_index_range, clk, rst_n, out_valid && out_has_payload, out_byte_index < out_payload_length, "payload index beyond length")

  // The last payload byte sits at the end of the declared length.
  `SLCFP_ASSERT_IMP(a_last_pos, clk, rst_n, out_valid && out_has_payload && out_last, out_byte_index + 6'd1 == out_payload_length, "last marker misplaced")

endmodule

bind sync_length_checksum_frame_parser slcfp_checker u_slcfp_checker (.*);

/* bench/tb_sync_length_checksum_frame_parser.sv */
// Self-checking testbench for the sync/length/checksum frame parser.
module tb_sync_length_checksum_frame_parser;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_FRAME_LEN = 64;
  localparam int CYCLE_LIMIT = 200_000;
  localparam int RANDOM_LIVE_BYTES = 24;
  localparam int DRAIN_CYCLES = 70;

  typedef logic [7:0] byte_q_t[$];

  // One result transaction as it appears on the out_ ports.
  typedef struct {
    logic [7:0] payload_byte;
    logic [5:0] byte_index;
    logic       has_payload;
    logic [1:0] frame_status;
    logic [5:0] payload_length;
    logic       last;
  } frame_result_t;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_ready;
  logic [7:0] in_rx_byte;
  logic       out_valid;
  logic       out_ready;
  logic [7:0] out_payload_byte;
  logic [5:0] out_byte_index;
  logic       out_has_payload;
  logic [1:0] out_frame_status;
  logic [5:0] out_payload_length;
  logic       out_last;

  // Parser state as the bench tracks it.
  int         rx_pos;
  logic [7:0] rx_len;
  logic [7:0] rx_sum;
  logic [7:0] rx_store [MAX_FRAME_LEN];

  frame_result_t frame_results_due[$];
  int mismatch_count;
  int live_bytes;
  int cycle_count;
  bit in_gaps_on;
  bit out_stalls_on;

  sync_length_checksum_frame_parser #(
    .MAX_FRAME_LEN(MAX_FRAME_LEN)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_payload_byte  (out_payload_byte),
    .out_byte_index    (out_byte_index),
    .out_has_payload   (out_has_payload),
    .out_frame_status  (out_frame_status),
    .out_payload_length(out_payload_length),
    .out_last          (out_last)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Idle lengths: mostly none or short, now and then a long one.
  function automatic int gap_cycles();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 2);
    if (r < 96) return $urandom_range(3, 6);
    return $urandom_range(12, 30);
  endfunction

  function automatic byte_q_t rand_body(input int n);
    byte_q_t q;
    repeat (n) q.push_back(8'($urandom_range(0, 255)));
    return q;
  endfunction

  task automatic queue_result(input logic [7:0] pbyte, input logic [5:0] idx,
                              input logic hasp, input logic [1:0] status,
                              input logic [5:0] plen, input logic last);
    frame_result_t r;
    r.payload_byte = pbyte;
    r.byte_index = idx;
    r.has_payload = hasp;
    r.frame_status = status;
    r.payload_length = plen;
    r.last = last;
    frame_results_due.push_back(r);
  endtask

  // Advances the tracked parser state by one received byte and queues the
  // results that the byte releases.
  task automatic parse_rx_byte(input logic [7:0] b);
    int n;
    if (rx_pos == 0) begin
      if (b == slcfp_pkg::SYNC_FIRST) begin
        rx_sum = b;
        rx_pos = 1;
      end
    end else if (rx_pos == 1) begin
      if (b == slcfp_pkg::SYNC_SECOND) begin
        rx_sum = rx_sum + b;
        rx_pos = 2;
      end else begin
        rx_pos = 0;
      end
    end else if (rx_pos == 2) begin
      rx_len = b;
      rx_sum = rx_sum + b;
      rx_pos = 3;
    end else if (rx_pos >= MAX_FRAME_LEN) begin
      // The frame has outgrown the store: the byte is dropped with it.
      rx_pos = 0;
      queue_result(8'd0, 6'd0, 1'b0, slcfp_pkg::ST_OVERFLOW,
                   (rx_len > slcfp_pkg::PLEN_SAT) ? 6'(slcfp_pkg::PLEN_SAT)
                                                  : rx_len[5:0], 1'b1);
    end else if (rx_pos + 1 == int'(rx_len) + int'(slcfp_pkg::FRAME_OVERHEAD)) begin
      // Checksum byte closes the frame.
      rx_pos = 0;
      n = rx_len;
      if (b != rx_sum) begin
        queue_result(8'd0, 6'd0, 1'b0, slcfp_pkg::ST_CHECKSUM, rx_len[5:0], 1'b1);
      end else if (n == 0) begin
        queue_result(8'd0, 6'd0, 1'b0, slcfp_pkg::ST_GOOD, 6'd0, 1'b1);
      end else begin
        for (int i = 0; i < n; i++) begin
          queue_result(rx_store[i], 6'(i), 1'b1, slcfp_pkg::ST_GOOD, rx_len[5:0],
                       i + 1 == n);
        end
      end
    end else begin
      rx_store[rx_pos - 3] = b;
      rx_sum = rx_sum + b;
      rx_pos++;
    end
  endtask

  // Sends one byte, waits for its transaction and then idles for a while.
  task automatic send_byte(input logic [7:0] b);
    int n;
    @(negedge clk);
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!(rx_pos == 0 && b != slcfp_pkg::SYNC_FIRST)) live_bytes++;
    parse_rx_byte(b);
    n = in_gaps_on ? gap_cycles() : 0;
    if (n > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      in_rx_byte <= 8'($urandom_range(0, 255));
      repeat (n - 1) @(negedge clk);
    end
  endtask

  // Sync pair, length, body and optionally a checksum with the given error.
  task automatic send_frame(input logic [7:0] len, input byte_q_t body,
                            input bit with_sum, input logic [7:0] sum_err);
    logic [7:0] sum;
    sum = slcfp_pkg::SYNC_FIRST + slcfp_pkg::SYNC_SECOND + len;
    send_byte(slcfp_pkg::SYNC_FIRST);
    send_byte(slcfp_pkg::SYNC_SECOND);
    send_byte(len);
    foreach (body[i]) begin
      send_byte(body[i]);
      sum = sum + body[i];
    end
    if (with_sum) send_byte(sum ^ sum_err);
  endtask

  // Noise while hunting, broken sync pairs and an empty frame.
  task automatic test_hunting();
    byte_q_t none;
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(slcfp_pkg::SYNC_SECOND);
    send_byte(8'h7F);
    send_byte(8'h80);
    send_byte(slcfp_pkg::SYNC_FIRST);
    send_byte(8'h00);
    // A repeated first sync byte breaks the pair and is not taken as a new one.
    send_byte(slcfp_pkg::SYNC_FIRST);
    send_byte(slcfp_pkg::SYNC_FIRST);
    send_byte(slcfp_pkg::SYNC_SECOND);
    send_frame(8'd0, none, 1'b1, 8'd0);
  endtask

  // A short good frame with extreme payload values and a checksum mismatch.
  task automatic test_short_frames();
    byte_q_t body;
    body = {8'h00, 8'hFF};
    send_frame(8'd2, body, 1'b1, 8'd0);
    body = {8'hA5};
    send_frame(8'd1, body, 1'b1, 8'h01);
  endtask

  // Longest frame that fits, and a frame that outgrows the store.
  task automatic test_length_limits();
    byte_q_t body;
    in_gaps_on = 1'b0;
    out_stalls_on = 1'b0;
    send_frame(8'd60, rand_body(60), 1'b1, 8'd0);
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    // The dropped byte is a first sync byte and must not start a new frame.
    send_frame(8'd61, rand_body(61), 1'b0, 8'd0);
    send_byte(slcfp_pkg::SYNC_FIRST);
    send_byte(slcfp_pkg::SYNC_SECOND);
    body = {8'hFF, 8'h00, 8'h5A};
    send_frame(8'd3, body, 1'b1, 8'd0);
  endtask

  // Mostly well-formed frames with random content, plus noise and broken ones.
  task automatic test_random();
    int pick;
    logic [7:0] len;
    live_bytes = 0;
    while (live_bytes < RANDOM_LIVE_BYTES) begin
      in_gaps_on = $urandom_range(0, 3) != 0;
      out_stalls_on = $urandom_range(0, 3) != 0;
      // Run any unfinished frame out before starting a clean one.
      while (rx_pos != 0) send_byte(8'($urandom_range(0, 255)));
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
        len = ($urandom_range(0, 9) != 0) ? 8'($urandom_range(0, 8))
                                           : 8'($urandom_range(9, 60));
        send_frame(len, rand_body(len), 1'b1, 8'd0);
      end else if (pick < 75) begin
        len = 8'($urandom_range(0, 12));
        send_frame(len, rand_body(len), 1'b1, 8'($urandom_range(1, 255)));
      end else if (pick < 82) begin
        len = 8'($urandom_range(61, 255));
        send_frame(len, rand_body(61), 1'b1, 8'($urandom_range(0, 255)));
      end else if (pick < 92) begin
        repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
      end else begin
        send_byte(slcfp_pkg::SYNC_FIRST);
        repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // Stops sending and waits for the parser to deliver everything still owed.
  task automatic test_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (frame_results_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic flag_error(input string what, input int want, input int got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t ns: %s: expected %0d, got %0d", $time, what, want, got);
    end
  endtask

  // Result receiver with random stalls on out_ready.
  initial begin
    int n;
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      n = out_stalls_on ? gap_cycles() : 0;
      if (n == 0) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b0;
        repeat (n - 1) @(negedge clk);
      end
    end
  end

  // Each result transaction is checked against the oldest one owed.
  always @(posedge clk) begin
    frame_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (frame_results_due.size() == 0) begin
        flag_error("result with none owed, payload byte", -1, out_payload_byte);
      end else begin
        want = frame_results_due.pop_front();
        if (out_payload_byte !== want.payload_byte)
          flag_error("out_payload_byte", want.payload_byte, out_payload_byte);
        if (out_byte_index !== want.byte_index)
          flag_error("out_byte_index", want.byte_index, out_byte_index);
        if (out_has_payload !== want.has_payload)
          flag_error("out_has_payload", want.has_payload, out_has_payload);
        if (out_frame_status !== want.frame_status)
          flag_error("out_frame_status", want.frame_status, out_frame_status);
        if (out_payload_length !== want.payload_length)
          flag_error("out_payload_length", want.payload_length, out_payload_length);
        if (out_last !== want.last)
          flag_error("out_last", want.last, out_last);
      end
    end
  end

  // Watchdog on the whole run.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("sync_length_checksum_frame_parser test failed");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'h00;
    rx_pos = 0;
    rx_len = 8'h00;
    rx_sum = 8'h00;
    mismatch_count = 0;
    live_bytes = 0;
    in_gaps_on = 1'b1;
    out_stalls_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_hunting();
    test_short_frames();
    test_length_limits();
    test_random();
    test_drain();

    if (mismatch_count == 0 && frame_results_due.size() == 0) begin
      $display("sync_length_checksum_frame_parser test passed");
    end else begin
      $display("sync_length_checksum_frame_parser test failed");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+rtl
rtl/slcfp_pkg.sv
rtl/slcfp_ram.sv
rtl/slcfp_rx.sv
rtl/slcfp_emit.sv
rtl/sync_length_checksum_frame_parser.sv
rtl/slcfp_checker.sv
bench/tb_sync_length_checksum_frame_parser.sv
